>>> hw/rtl/fcfa_pkg.sv
// Shared types and constants for the first-fit frame allocator.
package fcfa_pkg;

  localparam int REQ_W  = 11;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 4;
  localparam int SOFF_W = 10;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd3;

  typedef struct packed {
    logic              load;
    logic              scan;
    logic              mark;
    logic              fscan;
    logic              len;
    logic              clear;
    logic              res_we;
    logic              res_use_run;
    logic [STAT_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic bad_size;
    logic bad_off;
    logic fit;
    logic scan_last;
    logic fmatch;
    logic fover;
    logic is_head;
    logic ptr_last;
  } sts_t;

endpackage

>>> hw/rtl/first_fit_frame_allocator.sv
// Top level of the first-fit contiguous frame allocator.
// A beat is taken when start is high and busy is low, and exactly one result
// beat follows on out_valid for a single cycle; the receiver cannot stall it.
// A rejected size or an offset at or beyond the pool is answered without a scan.
// An allocate scans frames from 0, one frame per cycle, answers when a fitting
// run is found and then marks the run one frame per cycle; with no fitting run
// it answers no space at the last frame. A free scans up to the named head
// frame, reads the run length from the length RAM and clears the run one frame
// per cycle. The longest beat is a full-pool allocate: a scan over every frame
// followed by marking every frame. All frames are free after reset.
module first_fit_frame_allocator #(
  parameter int FRAME_COUNT = 16,
  parameter int FRAME_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [fcfa_pkg::REQ_W-1:0]  in_request_bytes,
  input  logic [fcfa_pkg::REQ_W-1:0]  in_byte_offset,
  output logic                        out_valid,
  output logic [fcfa_pkg::STAT_W-1:0] out_status,
  output logic [fcfa_pkg::FIDX_W-1:0] out_frame_index,
  output logic [fcfa_pkg::SOFF_W-1:0] out_start_offset
);

  fcfa_pkg::cmd_t cmd;
  fcfa_pkg::sts_t sts;

  fcfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  fcfa_datapath #(
    .FRAME_COUNT (FRAME_COUNT),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_request_bytes (in_request_bytes),
    .in_byte_offset   (in_byte_offset),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (out_status),
    .out_frame_index  (out_frame_index),
    .out_start_offset (out_start_offset)
  );

endmodule

>>> hw/rtl/fcfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/fcfa_datapath.sv
// Frame tables, scan counters and result registers of the allocator.
module fcfa_datapath #(
  parameter int FRAME_COUNT = 16,
  parameter int FRAME_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [fcfa_pkg::REQ_W-1:0]       in_request_bytes,
  input  logic [fcfa_pkg::REQ_W-1:0]       in_byte_offset,
  input  fcfa_pkg::cmd_t                   cmd,
  output fcfa_pkg::sts_t                   sts,
  output logic [fcfa_pkg::STAT_W-1:0]      out_status,
  output logic [fcfa_pkg::FIDX_W-1:0]      out_frame_index,
  output logic [fcfa_pkg::SOFF_W-1:0]      out_start_offset
);

  localparam int IDX_W = $clog2(FRAME_COUNT);
  localparam int LEN_W = $clog2(FRAME_COUNT + 1);
  localparam int POOL  = FRAME_COUNT * FRAME_BYTES;
  localparam int ACC_W = $clog2(POOL + FRAME_BYTES + 1);
  localparam int CMP_W = (ACC_W > fcfa_pkg::REQ_W) ? ACC_W : fcfa_pkg::REQ_W;
  localparam int RB_W  = $clog2((1 << fcfa_pkg::REQ_W) + FRAME_BYTES);
  localparam int FIT_W = (RB_W > fcfa_pkg::REQ_W) ? RB_W : fcfa_pkg::REQ_W;
  localparam int LAST  = FRAME_COUNT - 1;

  logic [FRAME_COUNT-1:0]          busy_r, busy_nxt;
  logic [FRAME_COUNT-1:0]          heads_r, heads_nxt;
  logic [IDX_W-1:0]                idx_r, ptr_r, end_r, run_start_r;
  logic [ACC_W-1:0]                acc_r, run_acc_r, acc_step;
  logic [RB_W-1:0]                 run_bytes_r, rb_step;
  logic [LEN_W-1:0]                run_cnt_r, rd_len;
  logic [fcfa_pkg::REQ_W-1:0]      req_r, off_r;
  logic [fcfa_pkg::STAT_W-1:0]     res_status_r;
  logic [fcfa_pkg::FIDX_W-1:0]     res_frame_r;
  logic [fcfa_pkg::SOFF_W-1:0]     res_off_r;
  logic                            cur_busy;
  logic                            ram_we;

  assign cur_busy = busy_r[idx_r];
  assign acc_step = acc_r + ACC_W'(FRAME_BYTES);
  assign rb_step  = run_bytes_r + RB_W'(FRAME_BYTES);
  assign ram_we   = cmd.scan && sts.fit;

  always_comb begin
    sts.bad_size  = (in_request_bytes == '0) ||
                    (CMP_W'(in_request_bytes) > CMP_W'(POOL));
    sts.bad_off   = CMP_W'(in_byte_offset) >= CMP_W'(POOL);
    sts.fit       = !cur_busy && (FIT_W'(rb_step) >= FIT_W'(req_r));
    sts.scan_last = idx_r == IDX_W'(LAST);
    sts.fmatch    = CMP_W'(acc_r) == CMP_W'(off_r);
    sts.fover     = CMP_W'(acc_r) > CMP_W'(off_r);
    sts.is_head   = heads_r[idx_r];
    sts.ptr_last  = ptr_r == end_r;
  end

  fcfa_ram #(
    .WIDTH (LEN_W),
    .DEPTH (FRAME_COUNT)
  ) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (run_start_r),
    .wdata (run_cnt_r + LEN_W'(1)),
    .raddr (idx_r),
    .rdata (rd_len)
  );

  always_comb begin
    busy_nxt  = busy_r;
    heads_nxt = heads_r;
    if (ram_we) begin
      heads_nxt[run_start_r] = 1'b1;
    end
    if (cmd.mark) begin
      busy_nxt[ptr_r] = 1'b1;
    end
    if (cmd.clear) begin
      busy_nxt[ptr_r]  = 1'b0;
      heads_nxt[ptr_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      heads_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      heads_r <= heads_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r       <= '0;
      acc_r       <= '0;
      run_start_r <= '0;
      run_acc_r   <= '0;
      run_bytes_r <= '0;
      run_cnt_r   <= '0;
      req_r       <= in_request_bytes;
      off_r       <= in_byte_offset;
    end
    if (cmd.scan) begin
      idx_r <= idx_r + IDX_W'(1);
      acc_r <= acc_step;
      if (cur_busy) begin
        run_start_r <= idx_r + IDX_W'(1);
        run_acc_r   <= acc_step;
        run_bytes_r <= '0;
        run_cnt_r   <= '0;
      end else begin
        run_bytes_r <= rb_step;
        run_cnt_r   <= run_cnt_r + LEN_W'(1);
      end
      if (sts.fit) begin
        ptr_r <= run_start_r;
        end_r <= idx_r;
      end
    end
    if (cmd.fscan) begin
      idx_r <= idx_r + IDX_W'(1);
      acc_r <= acc_step;
      ptr_r <= idx_r;
    end
    if (cmd.len) begin
      end_r <= ptr_r + IDX_W'(rd_len - LEN_W'(1));
    end
    if (cmd.mark || cmd.clear) begin
      ptr_r <= ptr_r + IDX_W'(1);
    end
    if (cmd.res_we) begin
      res_status_r <= cmd.res_status;
      res_frame_r  <= cmd.res_use_run ? fcfa_pkg::FIDX_W'(run_start_r) : '0;
      res_off_r    <= cmd.res_use_run ? fcfa_pkg::SOFF_W'(run_acc_r) : '0;
    end
  end

  assign out_status       = res_status_r;
  assign out_frame_index  = res_frame_r;
  assign out_start_offset = res_off_r;

endmodule

>>> hw/rtl/fcfa_ctrl.sv
// Sequencing state machine of the allocator.
module fcfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_func,
  input  fcfa_pkg::sts_t sts,
  output fcfa_pkg::cmd_t cmd,
  output logic           busy,
  output logic           out_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ASCAN = 3'd1;
  localparam logic [2:0] S_AMARK = 3'd2;
  localparam logic [2:0] S_FSCAN = 3'd3;
  localparam logic [2:0] S_FLEN  = 3'd4;
  localparam logic [2:0] S_FCLR  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_func == fcfa_pkg::FUNC_ALLOC) begin
            if (sts.bad_size) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = fcfa_pkg::ST_BAD_SIZE;
            end else begin
              state_nxt = S_ASCAN;
            end
          end else begin
            if (sts.bad_off) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = fcfa_pkg::ST_BAD_FREE;
            end else begin
              state_nxt = S_FSCAN;
            end
          end
        end
      end
      S_ASCAN: begin
        cmd.scan = 1'b1;
        if (sts.fit) begin
          cmd.res_we      = 1'b1;
          cmd.res_use_run = 1'b1;
          cmd.res_status  = fcfa_pkg::ST_OK;
          state_nxt       = S_AMARK;
        end else if (sts.scan_last) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = fcfa_pkg::ST_NO_SPACE;
          state_nxt      = S_IDLE;
        end
      end
      S_AMARK: begin
        cmd.mark = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_FSCAN: begin
        cmd.fscan = 1'b1;
        if (sts.fmatch && sts.is_head) begin
          state_nxt = S_FLEN;
        end else if (sts.fmatch || sts.fover || sts.scan_last) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = fcfa_pkg::ST_BAD_FREE;
          state_nxt      = S_IDLE;
        end
      end
      S_FLEN: begin
        cmd.len        = 1'b1;
        cmd.res_we     = 1'b1;
        cmd.res_status = fcfa_pkg::ST_OK;
        state_nxt      = S_FCLR;
      end
      S_FCLR: begin
        cmd.clear = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.res_we;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/fcfa_checker.sv
// Port-level checks for the frame allocator, bound to the top level.
module fcfa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [fcfa_pkg::STAT_W-1:0] out_status,
  input logic [fcfa_pkg::FIDX_W-1:0] out_frame_index,
  input logic [fcfa_pkg::SOFF_W-1:0] out_start_offset
);

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != fcfa_pkg::ST_OK |->
      out_frame_index == '0 && out_start_offset == '0)
    else $error("failed beat carries non-zero frame or offset");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted beat neither started work nor answered");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or strobe after reset");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result beat without a preceding request");

endmodule

bind first_fit_frame_allocator fcfa_checker u_fcfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_frame_index  (out_frame_index),
  .out_start_offset (out_start_offset)
);

>>> test/first_fit_frame_allocator_tb.sv
// Testbench for the first-fit frame allocator: directed and random beats against a pool model.
`timescale 1ns / 100ps

localparam int POOL_FRAMES     = 16;
localparam int BYTES_PER_FRAME = 64;
localparam int POOL_BYTES      = POOL_FRAMES * BYTES_PER_FRAME;

typedef struct packed {
  logic [fcfa_pkg::STAT_W-1:0] status;
  logic [fcfa_pkg::FIDX_W-1:0] frame_index;
  logic [fcfa_pkg::SOFF_W-1:0] start_offset;
} reply_t;

class frame_pool_tracker;
  bit     frame_used [POOL_FRAMES];
  int     run_frames [POOL_FRAMES];
  reply_t pending_replies [$];
  int     errors;

  function reply_t predict_reply(logic func, logic [fcfa_pkg::REQ_W-1:0] req,
                                 logic [fcfa_pkg::REQ_W-1:0] off);
    reply_t r;
    int     bytes;
    int     offset;
    int     need;
    int     head;
    int     len;
    bit     fits;
    bit     placed;
    r      = '0;
    bytes  = int'(req);
    offset = int'(off);
    placed = 0;
    if (func == fcfa_pkg::FUNC_ALLOC) begin
      if (bytes == 0 || bytes > POOL_BYTES) begin
        r.status = fcfa_pkg::ST_BAD_SIZE;
      end else begin
        need     = (bytes + BYTES_PER_FRAME - 1) / BYTES_PER_FRAME;
        r.status = fcfa_pkg::ST_NO_SPACE;
        for (head = 0; !placed && head + need <= POOL_FRAMES; head++) begin
          fits = 1;
          for (int i = 0; i < need; i++) begin
            if (frame_used[head + i]) fits = 0;
          end
          if (fits) begin
            for (int i = 0; i < need; i++) frame_used[head + i] = 1;
            run_frames[head] = need;
            r.status         = fcfa_pkg::ST_OK;
            r.frame_index    = fcfa_pkg::FIDX_W'(head);
            r.start_offset   = fcfa_pkg::SOFF_W'(head * BYTES_PER_FRAME);
            placed           = 1;
          end
        end
      end
    end else begin
      if (offset >= POOL_BYTES || offset % BYTES_PER_FRAME != 0) begin
        r.status = fcfa_pkg::ST_BAD_FREE;
      end else begin
        head = offset / BYTES_PER_FRAME;
        len  = run_frames[head];
        if (len == 0) begin
          r.status = fcfa_pkg::ST_BAD_FREE;
        end else begin
          for (int i = 0; i < len && head + i < POOL_FRAMES; i++) begin
            frame_used[head + i] = 0;
            run_frames[head + i] = 0;
          end
          r.status = fcfa_pkg::ST_OK;
        end
      end
    end
    return r;
  endfunction

  function void note_request(logic func, logic [fcfa_pkg::REQ_W-1:0] req,
                             logic [fcfa_pkg::REQ_W-1:0] off);
    pending_replies.push_back(predict_reply(func, req, off));
  endfunction

  function void check_reply(reply_t got);
    reply_t exp;
    if (pending_replies.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected reply: status %0d index %0d offset %0d",
                 got.status, got.frame_index, got.start_offset);
    end else begin
      exp = pending_replies.pop_front();
      if (got.status != exp.status || got.frame_index != exp.frame_index ||
          got.start_offset != exp.start_offset) begin
        errors++;
        if (errors <= 10)
          $display("reply mismatch: expected status %0d index %0d offset %0d, %s %0d %0d %0d",
                   exp.status, exp.frame_index, exp.start_offset, "got",
                   got.status, got.frame_index, got.start_offset);
      end
    end
  endfunction

  function int pick_head_offset();
    int heads [$];
    for (int f = 0; f < POOL_FRAMES; f++) begin
      if (run_frames[f] != 0) heads.push_back(f);
    end
    if (heads.size() == 0) return -1;
    return heads[$urandom_range(0, heads.size() - 1)] * BYTES_PER_FRAME;
  endfunction

  function int tally();
    if (pending_replies.size() != 0) begin
      errors++;
      if (errors <= 10) $display("%0d replies never arrived", pending_replies.size());
    end
    return errors;
  endfunction
endclass

module first_fit_frame_allocator_tb;

  localparam int RANDOM_BEATS = 630;
  localparam int DRAIN_CYCLES = 2 * POOL_FRAMES + 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_func;
  logic [fcfa_pkg::REQ_W-1:0]  in_request_bytes;
  logic [fcfa_pkg::REQ_W-1:0]  in_byte_offset;
  logic                        out_valid;
  logic [fcfa_pkg::STAT_W-1:0] out_status;
  logic [fcfa_pkg::FIDX_W-1:0] out_frame_index;
  logic [fcfa_pkg::SOFF_W-1:0] out_start_offset;

  frame_pool_tracker board;
  int                cycle_count = 0;

  first_fit_frame_allocator #(
    .FRAME_COUNT(POOL_FRAMES),
    .FRAME_BYTES(BYTES_PER_FRAME)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_request_bytes(in_request_bytes),
    .in_byte_offset  (in_byte_offset),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_frame_index (out_frame_index),
    .out_start_offset(out_start_offset)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("first_fit_frame_allocator_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_reply({out_status, out_frame_index, out_start_offset});
      if (start && !busy) board.note_request(in_func, in_request_bytes, in_byte_offset);
    end
  end

  function automatic int pick_gap(int n);
    int r;
    r = $urandom_range(0, 99);
    if ((n / 50) % 4 == 3) return 0;
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold start low for the gap, then stop at the falling edge of the next beat
  task automatic next_slot(int gap);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
  endtask

  task automatic drive_beat(logic func, logic [fcfa_pkg::REQ_W-1:0] req,
                            logic [fcfa_pkg::REQ_W-1:0] off);
    in_func          = func;
    in_request_bytes = req;
    in_byte_offset   = off;
    start            = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic directed_beat(logic func, int value);
    next_slot($urandom_range(0, 2));
    if (func == fcfa_pkg::FUNC_ALLOC)
      drive_beat(func, fcfa_pkg::REQ_W'(value), fcfa_pkg::REQ_W'($urandom_range(0, 2047)));
    else
      drive_beat(func, fcfa_pkg::REQ_W'($urandom_range(0, 2047)), fcfa_pkg::REQ_W'(value));
  endtask

  initial begin
    int r;
    int off;
    int s;
    logic [fcfa_pkg::REQ_W-1:0] req;
    board            = new();
    rst_n            = 1'b0;
    start            = 1'b0;
    in_func          = fcfa_pkg::FUNC_ALLOC;
    in_request_bytes = '0;
    in_byte_offset   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_beat(fcfa_pkg::FUNC_ALLOC, 0);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 1025);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 2047);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 1);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 64);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 65);
    directed_beat(fcfa_pkg::FUNC_FREE, 64);
    directed_beat(fcfa_pkg::FUNC_FREE, 192);
    directed_beat(fcfa_pkg::FUNC_FREE, 1024);
    directed_beat(fcfa_pkg::FUNC_FREE, 2047);
    directed_beat(fcfa_pkg::FUNC_FREE, 32);
    directed_beat(fcfa_pkg::FUNC_FREE, 64);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 64);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 1024);
    directed_beat(fcfa_pkg::FUNC_FREE, 0);
    directed_beat(fcfa_pkg::FUNC_FREE, 64);
    directed_beat(fcfa_pkg::FUNC_FREE, 128);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 1024);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 1);
    directed_beat(fcfa_pkg::FUNC_FREE, 960);
    directed_beat(fcfa_pkg::FUNC_FREE, 0);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 960);
    directed_beat(fcfa_pkg::FUNC_ALLOC, 64);
    directed_beat(fcfa_pkg::FUNC_FREE, 960);
    directed_beat(fcfa_pkg::FUNC_FREE, 0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      next_slot(pick_gap(n));
      r   = $urandom_range(0, 99);
      off = board.pick_head_offset();
      if (r >= 50 && r < 88 && off >= 0) begin
        drive_beat(fcfa_pkg::FUNC_FREE, fcfa_pkg::REQ_W'($urandom_range(0, 2047)),
                   fcfa_pkg::REQ_W'(off));
      end else if (r >= 88) begin
        s = $urandom_range(0, 2);
        if (s == 0) off = $urandom_range(0, 2047);
        else if (s == 1) off = $urandom_range(0, POOL_FRAMES - 1) * BYTES_PER_FRAME;
        else off = $urandom_range(POOL_BYTES, 2047);
        drive_beat(fcfa_pkg::FUNC_FREE, fcfa_pkg::REQ_W'($urandom_range(0, 2047)),
                   fcfa_pkg::REQ_W'(off));
      end else begin
        s = $urandom_range(0, 19);
        if (r >= 45 && r < 50)
          req = ($urandom_range(0, 1) == 0) ? '0 : fcfa_pkg::REQ_W'($urandom_range(1025, 2047));
        else if (s < 12) req = fcfa_pkg::REQ_W'($urandom_range(1, 192));
        else if (s < 18) req = fcfa_pkg::REQ_W'($urandom_range(1, POOL_BYTES));
        else req = (s == 18) ? fcfa_pkg::REQ_W'(POOL_BYTES) : fcfa_pkg::REQ_W'(1);
        drive_beat(fcfa_pkg::FUNC_ALLOC, req, fcfa_pkg::REQ_W'($urandom_range(0, 2047)));
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.tally() == 0) begin
      $display("first_fit_frame_allocator_tb: clean");
    end else begin
      $display("first_fit_frame_allocator_tb: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/fcfa_pkg.sv
hw/rtl/fcfa_ram.sv
hw/rtl/fcfa_datapath.sv
hw/rtl/fcfa_ctrl.sv
hw/rtl/first_fit_frame_allocator.sv
hw/rtl/fcfa_checker.sv
test/first_fit_frame_allocator_tb.sv
